// File: sv/fvg_pkg.sv
// Shared constants and divider interface types for the FAT volume geometry unit.
`default_nettype none
package fvg_pkg;

  localparam int unsigned DivNumW = 32;
  localparam int unsigned DivDenW = 24;
  localparam int unsigned DivCntW = 6;

  localparam logic [31:0] LimNarrow  = 32'h0000_FFFF;
  localparam logic [31:0] LimWide    = 32'h007F_FFFF;
  localparam logic [28:0] SpfLimit   = 29'h0_FFFF;
  localparam logic [22:0] Fat12Top   = 23'd4077;
  localparam logic [22:0] Fat16Low   = 23'd4088;
  localparam logic [22:0] Fat16Top   = 23'd65518;
  localparam logic [19:0] ClusterCap = 20'd65536;

  localparam logic RegReserved = 1'b0;
  localparam logic RegWide     = 1'b1;

  typedef struct packed {
    logic               go;
    logic [DivNumW-1:0] num;
    logic [DivDenW-1:0] den;
  } fvg_div_req_t;

  typedef struct packed {
    logic               done;
    logic [DivNumW-1:0] quo;
    logic [DivDenW-1:0] rem;
  } fvg_div_rsp_t;

endpackage
`default_nettype wire

// File: sv/fat_volume_geometry_unit.sv
// Top level of the FAT12/FAT16 volume geometry unit with its sequencer.
// The result strobe follows an accepted transfer once the layout passes settle; every
// division runs on the shared divider. A sector doubling, a repeated pass or a FAT-size
// retry each adds divisions; a zero sector size or oversized cluster request answers
// straight from idle without a division.
// One request at a time; busy_o drops with the strobe and the receiver cannot stall.
// Reset is asynchronous and active low; registers return to reserved=1, narrow.
`default_nettype none
module fat_volume_geometry_unit
  import fvg_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [20:0] size_kb_i,
  input  wire logic [15:0] sector_bytes_i,
  input  wire logic [16:0] cluster_req_bytes_i,
  input  wire logic [15:0] root_entries_i,
  input  wire logic [4:0]  fat_copies_i,
  output logic             done_o,
  output logic             ok_o,
  output logic             fat16_o,
  output logic      [16:0] final_sector_bytes_o,
  output logic      [16:0] final_cluster_bytes_o,
  output logic      [22:0] total_sectors_o,
  output logic      [11:0] sectors_per_cluster_o,
  output logic      [15:0] dir_sector_count_o,
  output logic      [15:0] fat_sector_count_o,
  output logic      [15:0] cluster_count_o,
  output logic      [19:0] dir_first_sector_o,
  output logic      [22:0] data_sector_count_o
);

  // The sequencer walks the layout passes; every division goes through the
  // one shared divider, and each state that awaits a division holds until its done pulse.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEC,
    ST_DIR,
    ST_LOOP,
    ST_SPC,
    ST_SPF,
    ST_CLU
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [7:0] reserved_q;
  logic       wide_q;

  assign pready = 1'b1;
  always_comb begin
    if (paddr[2] == RegWide) begin
      prdata = {31'd0, wide_q};
    end else begin
      prdata = {24'd0, reserved_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reserved_q <= 8'd1;
      wide_q     <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == RegReserved) begin
        reserved_q <= pwdata[7:0];
      end else begin
        wide_q <= pwdata[0];
      end
    end
  end

  // Working registers of one request.
  logic [30:0] bytes_q;
  logic [17:0] bps_q;
  logic [19:0] clus_q;
  logic [15:0] ent_q;
  logic [4:0]  fats_q;
  logic        size_zero_q;
  logic        bits16_q;
  logic        grow_q;
  logic [22:0] sectors_q;
  logic [21:0] dirsec_q;
  logic [23:0] sys_q;
  logic [22:0] data_q;
  logic [19:0] spc_q;
  logic [15:0] spf_q;
  logic [20:0] fsec_q;

  fvg_div_req_t div_req_q;
  fvg_div_rsp_t div_rsp;

  fvg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .rsp_o  (div_rsp)
  );

  // Helper values drawn from the divider result and the working registers.
  logic [31:0] lim;
  logic [21:0] dirsec_new;
  logic [19:0] clus_max;
  logic [23:0] sys_new;
  logic [22:0] data_new;
  logic [28:0] spf_new;
  logic [23:0] spf_base;
  logic [27:0] spf_num;
  logic [23:0] spf_den;
  logic [20:0] fsec_new;
  logic [23:0] sys_fat;
  logic [22:0] data_fat;
  logic [22:0] nclus;
  logic [19:0] clus_dbl;

  assign lim        = wide_q ? LimWide : LimNarrow;
  assign dirsec_new = 22'(div_rsp.quo) + {21'd0, (div_rsp.rem != '0)};
  assign clus_max   = ({2'd0, bps_q} > clus_q) ? {2'd0, bps_q} : clus_q;
  assign sys_new    = {16'd0, reserved_q} + {2'd0, dirsec_q};
  assign data_new   = ({1'b0, sectors_q} > sys_new) ? 23'({1'b0, sectors_q} - sys_new) : '0;
  assign spf_base   = {1'b0, data_q} + {3'd0, div_rsp.quo[19:0], 1'b0};
  // The FAT entry width is 12 or 16 bits, so both products are shifts and adds.
  assign spf_num    = bits16_q ? {spf_base, 4'd0}
                               : ({1'b0, spf_base, 3'd0} + {2'd0, spf_base, 2'd0});
  assign spf_den    = {1'b0, clus_q, 3'd0}
                    + (bits16_q ? {15'd0, fats_q, 4'd0}
                                : ({16'd0, fats_q, 3'd0} + {17'd0, fats_q, 2'd0}));
  assign spf_new    = 29'(div_rsp.quo) + {28'd0, (div_rsp.rem != '0)};
  assign fsec_new   = {5'd0, spf_new[15:0]} * {16'd0, fats_q};
  assign sys_fat    = sys_q + {3'd0, fsec_new};
  assign data_fat   = (data_q > {2'd0, fsec_new}) ? (data_q - {2'd0, fsec_new}) : '0;
  assign nclus      = div_rsp.quo[22:0];
  assign clus_dbl   = {clus_q[18:0], 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      div_req_q     <= '0;
      done_o        <= 1'b0;
      grow_q        <= 1'b0;
      bits16_q      <= 1'b0;
    end else begin
      div_req_q.go <= 1'b0;
      done_o       <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            bytes_q     <= {size_kb_i, 10'd0};
            bps_q       <= {2'd0, sector_bytes_i};
            clus_q      <= {3'd0, cluster_req_bytes_i};
            ent_q       <= root_entries_i;
            fats_q      <= fat_copies_i;
            size_zero_q <= (size_kb_i == '0);
            bits16_q    <= 1'b0;
            grow_q      <= 1'b0;
            if (sector_bytes_i == '0 || {3'd0, cluster_req_bytes_i} > ClusterCap) begin
              done_o                <= 1'b1;
              ok_o                  <= 1'b0;
              fat16_o               <= 1'b0;
              final_sector_bytes_o  <= '0;
              final_cluster_bytes_o <= '0;
              total_sectors_o       <= '0;
              sectors_per_cluster_o <= '0;
              dir_sector_count_o    <= '0;
              fat_sector_count_o    <= '0;
              cluster_count_o       <= '0;
              dir_first_sector_o    <= '0;
              data_sector_count_o   <= '0;
            end else begin
              div_req_q <= '{go: 1'b1, num: {1'b0, size_kb_i, 10'd0},
                             den: {8'd0, sector_bytes_i}};
              state_q   <= ST_SEC;
            end
          end
        end
        ST_SEC: begin
          if (div_rsp.done) begin
            if (!grow_q && div_rsp.quo > lim) begin
              bps_q     <= {bps_q[16:0], 1'b0};
              div_req_q <= '{go: 1'b1, num: {1'b0, bytes_q},
                             den: {6'd0, bps_q[16:0], 1'b0}};
            end else begin
              sectors_q <= div_rsp.quo[22:0];
              div_req_q <= '{go: 1'b1, num: {11'd0, ent_q, 5'd0}, den: {6'd0, bps_q}};
              state_q   <= ST_DIR;
            end
          end
        end
        ST_DIR: begin
          if (div_rsp.done) begin
            dirsec_q <= dirsec_new;
            clus_q   <= clus_max;
            grow_q   <= 1'b0;
            if (grow_q && clus_max > ClusterCap) begin
              done_o                <= 1'b1;
              ok_o                  <= 1'b0;
              fat16_o               <= 1'b0;
              final_sector_bytes_o  <= '0;
              final_cluster_bytes_o <= '0;
              total_sectors_o       <= '0;
              sectors_per_cluster_o <= '0;
              dir_sector_count_o    <= '0;
              fat_sector_count_o    <= '0;
              cluster_count_o       <= '0;
              dir_first_sector_o    <= '0;
              data_sector_count_o   <= '0;
              state_q               <= ST_IDLE;
            end else begin
              state_q <= ST_LOOP;
            end
          end
        end
        ST_LOOP: begin
          // Start of one pass of the sectors-per-FAT iteration.
          sys_q     <= sys_new;
          data_q    <= data_new;
          div_req_q <= '{go: 1'b1, num: {12'd0, clus_q}, den: {6'd0, bps_q}};
          state_q   <= ST_SPC;
        end
        ST_SPC: begin
          if (div_rsp.done) begin
            spc_q     <= div_rsp.quo[19:0];
            div_req_q <= '{go: 1'b1, num: {4'd0, spf_num}, den: spf_den};
            state_q   <= ST_SPF;
          end
        end
        ST_SPF: begin
          if (div_rsp.done) begin
            if (spf_new > SpfLimit) begin
              // One FAT is too large: grow a small sector first, else the cluster.
              if (bps_q < 18'd512) begin
                bps_q     <= {bps_q[16:0], 1'b0};
                grow_q    <= 1'b1;
                div_req_q <= '{go: 1'b1, num: {1'b0, bytes_q},
                               den: {6'd0, bps_q[16:0], 1'b0}};
                state_q   <= ST_SEC;
              end else begin
                clus_q <= clus_dbl;
                if (clus_dbl > ClusterCap) begin
                  done_o                <= 1'b1;
                  ok_o                  <= 1'b0;
                  fat16_o               <= 1'b0;
                  final_sector_bytes_o  <= '0;
                  final_cluster_bytes_o <= '0;
                  total_sectors_o       <= '0;
                  sectors_per_cluster_o <= '0;
                  dir_sector_count_o    <= '0;
                  fat_sector_count_o    <= '0;
                  cluster_count_o       <= '0;
                  dir_first_sector_o    <= '0;
                  data_sector_count_o   <= '0;
                  state_q               <= ST_IDLE;
                end else begin
                  state_q <= ST_LOOP;
                end
              end
            end else begin
              spf_q     <= spf_new[15:0];
              fsec_q    <= fsec_new;
              sys_q     <= sys_fat;
              data_q    <= data_fat;
              div_req_q <= '{go: 1'b1, num: {9'd0, data_fat}, den: {4'd0, spc_q}};
              state_q   <= ST_CLU;
            end
          end
        end
        ST_CLU: begin
          if (div_rsp.done) begin
            if (!bits16_q && nclus > Fat12Top) begin
              bits16_q <= 1'b1;
              state_q  <= ST_LOOP;
            end else if ((bits16_q && nclus < Fat16Low) || nclus > Fat16Top) begin
              // Too few clusters for FAT16 or too many for either: back to
              // FAT12 with a doubled cluster.
              bits16_q <= 1'b0;
              clus_q   <= clus_dbl;
              if (clus_dbl > ClusterCap) begin
                done_o                <= 1'b1;
                ok_o                  <= 1'b0;
                fat16_o               <= 1'b0;
                final_sector_bytes_o  <= '0;
                final_cluster_bytes_o <= '0;
                total_sectors_o       <= '0;
                sectors_per_cluster_o <= '0;
                dir_sector_count_o    <= '0;
                fat_sector_count_o    <= '0;
                cluster_count_o       <= '0;
                dir_first_sector_o    <= '0;
                data_sector_count_o   <= '0;
                state_q               <= ST_IDLE;
              end else begin
                state_q <= ST_LOOP;
              end
            end else begin
              // Layout settled; a zero size reports an empty but valid disk,
              // and a usable layout trims the sectors left outside a cluster.
              done_o                <= 1'b1;
              fat16_o               <= bits16_q;
              final_sector_bytes_o  <= bps_q[16:0];
              final_cluster_bytes_o <= clus_q[16:0];
              sectors_per_cluster_o <= spc_q[11:0];
              dir_sector_count_o    <= dirsec_q[15:0];
              fat_sector_count_o    <= spf_q;
              dir_first_sector_o    <= 20'({14'd0, reserved_q} + {1'b0, fsec_q});
              if (size_zero_q) begin
                ok_o                <= 1'b1;
                total_sectors_o     <= '0;
                cluster_count_o     <= '0;
                data_sector_count_o <= '0;
              end else if ({1'b0, sectors_q} <= sys_q || nclus == '0) begin
                ok_o                <= 1'b0;
                total_sectors_o     <= sectors_q;
                cluster_count_o     <= nclus[15:0];
                data_sector_count_o <= data_q;
              end else begin
                ok_o                <= 1'b1;
                total_sectors_o     <= sectors_q - div_rsp.rem[22:0];
                cluster_count_o     <= nclus[15:0];
                data_sector_count_o <= data_q;
              end
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o = (state_q != ST_IDLE);

  // A result transfer only ever follows the end of a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy_o)
    else $error("result strobe while busy");

  // An accepted request either finishes at once with an error or starts work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || done_o))
    else $error("accepted request was dropped");

  // The divider is only launched while a request is in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni) div_req_q.go |-> busy_o)
    else $error("divider launched while idle");

  // The working sector size is never zero while a request runs outside ST_SEC.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_o && state_q != ST_SEC) |-> (bps_q != '0))
    else $error("zero sector size inside the sequencer");

endmodule
`default_nettype wire

// File: sv/fvg_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
`default_nettype none
module fvg_div
  import fvg_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire fvg_div_req_t req_i,
  output fvg_div_rsp_t      rsp_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [DivNumW-1:0] quo_q, quo_d;
  logic [DivDenW-1:0] rem_q, rem_d;
  logic [DivDenW-1:0] den_q, den_d;
  logic [DivDenW:0]   shifted;

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    den_d   = den_q;
    shifted = {rem_q, quo_q[DivNumW-1]};
    if (req_i.go) begin
      busy_d = 1'b1;
      cnt_d  = DivCntW'(DivNumW);
      quo_d  = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
    end else if (busy_q) begin
      if (shifted >= {1'b0, den_q}) begin
        rem_d = DivDenW'(shifted - {1'b0, den_q});
        quo_d = {quo_q[DivNumW-2:0], 1'b1};
      end else begin
        rem_d = shifted[DivDenW-1:0];
        quo_d = {quo_q[DivNumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - DivCntW'(1);
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o = '{done: done_q, quo: quo_q, rem: rem_q};

endmodule
`default_nettype wire
